// ----- sv/fbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame brightness statistics package
// Shared widths, constants, payload types and the back-end state encoding.
// ----------------------------------------------------------------------------
package fbs_pkg;

    localparam int unsigned PIX_W            = 8;
    localparam logic [7:0]  PIX_MAX          = 8'hFF;
    localparam int unsigned MEAN_W           = 15;
    localparam int unsigned MEAN_SCALE       = 100;
    localparam int unsigned OUT_TOTAL_W      = 28;
    localparam int unsigned OUT_BYTES_W      = 20;
    localparam int unsigned FRAME_CNT_W_DEF  = 20;
    localparam int unsigned RUN_CNT_W_DEF    = 40;
    localparam int unsigned QUEUE_DEPTH      = 4;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_end;
    } t_pix;

    typedef struct packed {
        logic [MEAN_W-1:0]      frame_mean_x100;
        logic [PIX_W-1:0]       frame_min;
        logic [PIX_W-1:0]       frame_max;
        logic [OUT_TOTAL_W-1:0] frame_total;
        logic [OUT_BYTES_W-1:0] frame_bytes;
        logic [MEAN_W-1:0]      run_mean_x100;
        logic [PIX_W-1:0]       run_min;
        logic [PIX_W-1:0]       run_max;
        logic                   frame_overflow;
        logic                   overall_overflow;
    } t_res;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_FOLD,
        BK_FDIV,
        BK_RDIV,
        BK_OUT
    } t_back_state;

endpackage

// ----- sv/fbs_pix_if.sv -----
// ----------------------------------------------------------------------------
// Pixel stream interface
// Valid/ready channel carrying one pixel byte and its end-of-frame mark.
// ----------------------------------------------------------------------------
interface fbs_pix_if;
    logic          valid;
    logic          ready;
    fbs_pkg::t_pix data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/fbs_res_if.sv -----
// ----------------------------------------------------------------------------
// Statistics result interface
// Valid/ready channel carrying one per-frame statistics record.
// ----------------------------------------------------------------------------
interface fbs_res_if;
    logic          valid;
    logic          ready;
    fbs_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/frame_brightness_stats_unit.sv -----
// ----------------------------------------------------------------------------
// Frame brightness statistics unit
// Per-frame and running min, max, sum, count and mean of a pixel byte stream.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                                   Transfer
//  i_pix     in   pixel, frame_end                          one pixel byte
//  o_res     out  frame and running min/max/mean, totals    one per frame
//
//  The accumulator takes one pixel every cycle. In the back end each frame
//  is popped from the queue, folded into the running totals, then both
//  means are worked out in turn on the shared divider that produces one
//  quotient bit per cycle, and the result is loaded into the output
//  register once the output is free. Up to four finished frames wait in
//  the record queue; the pixel input stalls only while that queue is full.
//  Synchronous reset clears all totals; no clearing pass.
// ----------------------------------------------------------------------------
module frame_brightness_stats_unit #(
    parameter int unsigned FRAME_COUNT_WIDTH = fbs_pkg::FRAME_CNT_W_DEF,
    parameter int unsigned RUN_COUNT_WIDTH   = fbs_pkg::RUN_CNT_W_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fbs_pix_if.sink       i_pix,
    fbs_res_if.source     o_res
);
    localparam int unsigned REC_W = 2 * FRAME_COUNT_WIDTH + 25;

    logic             front_ready;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic [REC_W-1:0] q_wdata;
    logic [REC_W-1:0] q_rdata;

    assign i_pix.ready = front_ready;

    fbs_front #(
        .FRAME_COUNT_WIDTH (FRAME_COUNT_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .i_data  (i_pix.data),
        .o_ready (front_ready),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_rec   (q_wdata)
    );

    fbs_fifo #(
        .WIDTH (REC_W),
        .DEPTH (fbs_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    fbs_back #(
        .FRAME_COUNT_WIDTH (FRAME_COUNT_WIDTH),
        .RUN_COUNT_WIDTH   (RUN_COUNT_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (q_rdata),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_data  (o_res.data)
    );

    // A frame always holds at least one byte, so its extremes are ordered.
    a_frame_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.data.frame_min <= o_res.data.frame_max))
        else $error("frame minimum above frame maximum");

    // The running extremes include the frame just reported.
    a_overall_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.data.run_min <= o_res.data.frame_min &&
                         o_res.data.run_max >= o_res.data.frame_max))
        else $error("running extremes do not cover the frame");

    // The frame mean lies between the frame extremes scaled by 100.
    a_mean_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |->
            ({1'b0, o_res.data.frame_mean_x100} <=
                 16'(o_res.data.frame_max) * 16'd100 &&
             {1'b0, o_res.data.frame_mean_x100} >=
                 16'(o_res.data.frame_min) * 16'd100))
        else $error("frame mean outside frame range");

    // The queue is never written while full.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !q_push)
        else $error("record queue overrun");
endmodule

// ----- sv/fbs_front.sv -----
// ----------------------------------------------------------------------------
// Frame accumulator
// Takes one pixel per cycle while the queue is not full, keeps the frame sum,
// count, min and max, and pushes a frame record into the queue on the last
// byte of each frame.
module fbs_front #(
    parameter int unsigned FRAME_COUNT_WIDTH = fbs_pkg::FRAME_CNT_W_DEF,
    localparam int unsigned REC_W = 2 * FRAME_COUNT_WIDTH + 25
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  fbs_pkg::t_pix      i_data,
    output logic               o_ready,
    input  logic               i_full,
    output logic               o_push,
    output logic [REC_W-1:0]   o_rec
);
    localparam int unsigned FW = FRAME_COUNT_WIDTH;
    localparam int unsigned SW = FW + 8;

    logic [SW-1:0] r_fsum, n_fsum;
    logic [FW-1:0] r_fcnt, n_fcnt;
    logic [7:0]    r_fmin, n_fmin;
    logic [7:0]    r_fmax, n_fmax;
    logic          r_fsat, n_fsat;
    logic          sat_now;
    logic          accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && i_data.frame_end;

    always_comb begin
        sat_now = (r_fcnt == {FW{1'b1}});
        n_fcnt  = sat_now ? r_fcnt : r_fcnt + FW'(1);
        n_fsum  = sat_now ? r_fsum : r_fsum + SW'(i_data.pixel);
        n_fmin  = (i_data.pixel < r_fmin) ? i_data.pixel : r_fmin;
        n_fmax  = (i_data.pixel > r_fmax) ? i_data.pixel : r_fmax;
        n_fsat  = r_fsat || sat_now;
    end

    assign o_rec = {n_fsum, n_fcnt, n_fmin, n_fmax, n_fsat};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsum <= '0;
            r_fcnt <= '0;
            r_fmin <= fbs_pkg::PIX_MAX;
            r_fmax <= '0;
            r_fsat <= 1'b0;
        end else if (accept) begin
            if (i_data.frame_end) begin
                // The record leaves with this transfer; start the next frame clean.
                r_fsum <= '0;
                r_fcnt <= '0;
                r_fmin <= fbs_pkg::PIX_MAX;
                r_fmax <= '0;
                r_fsat <= 1'b0;
            end else begin
                r_fsum <= n_fsum;
                r_fcnt <= n_fcnt;
                r_fmin <= n_fmin;
                r_fmax <= n_fmax;
                r_fsat <= n_fsat;
            end
        end
    end
endmodule

// ----- sv/fbs_fifo.sv -----
// ----------------------------------------------------------------------------
// Frame record queue
// Small register queue that decouples the accumulator from the back end.
// ----------------------------------------------------------------------------
module fbs_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = fbs_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [PW:0]      r_count;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end
endmodule

// ----- sv/fbs_divider.sv -----
// ----------------------------------------------------------------------------
// Mean divider
// Computes floor(sum * 100 / count) by restoring division, one quotient bit
// per cycle. The quotient is known to fit in the mean width because the sum
// never exceeds 255 times the count. A zero count gives zero.
// ----------------------------------------------------------------------------
module fbs_divider #(
    parameter int unsigned CNT_W = fbs_pkg::RUN_CNT_W_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [CNT_W+7:0]           i_sum,
    input  logic [CNT_W-1:0]           i_cnt,
    output logic                       o_done,
    output logic [fbs_pkg::MEAN_W-1:0] o_quot
);
    localparam int unsigned QW     = fbs_pkg::MEAN_W;
    localparam int unsigned NW     = CNT_W + 15;
    localparam int unsigned STEP_W = $clog2(QW);

    logic [NW-1:0]     r_rem;
    logic [NW-1:0]     r_dsh;
    logic [QW-1:0]     r_q;
    logic [STEP_W-1:0] r_step;
    logic              r_zero;
    logic              r_busy;
    logic              r_done;
    logic              ge;

    assign ge     = (r_rem >= r_dsh);
    assign o_done = r_done;
    assign o_quot = r_zero ? '0 : r_q;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= NW'(i_sum) * NW'(fbs_pkg::MEAN_SCALE);
            r_dsh  <= NW'(i_cnt) << (QW - 1);
            r_zero <= (i_cnt == '0);
            r_q    <= '0;
            r_step <= STEP_W'(QW - 1);
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q    <= {r_q[QW-2:0], ge};
            r_dsh  <= r_dsh >> 1;
            r_step <= r_step - STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end
endmodule

// ----- sv/fbs_back.sv -----
// ----------------------------------------------------------------------------
// Statistics back end
// Pops frame records, folds them into the running totals, works out both
// means on a shared divider and holds the result in an output register.
// ----------------------------------------------------------------------------
module fbs_back #(
    parameter int unsigned FRAME_COUNT_WIDTH = fbs_pkg::FRAME_CNT_W_DEF,
    parameter int unsigned RUN_COUNT_WIDTH   = fbs_pkg::RUN_CNT_W_DEF,
    localparam int unsigned REC_W = 2 * FRAME_COUNT_WIDTH + 25
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [REC_W-1:0] i_rec,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output fbs_pkg::t_res    o_data
);
    localparam int unsigned FW = FRAME_COUNT_WIDTH;
    localparam int unsigned RW = RUN_COUNT_WIDTH;
    localparam int unsigned DW = (FW > RW) ? FW : RW;

    fbs_pkg::t_back_state r_state, n_state;

    logic [FW+7:0] r_rec_sum;
    logic [FW-1:0] r_rec_cnt;
    logic [7:0]    r_rec_min;
    logic [7:0]    r_rec_max;
    logic          r_rec_sat;

    logic [RW+7:0] r_run_sum;
    logic [RW-1:0] r_run_cnt;
    logic [7:0]    r_run_min;
    logic [7:0]    r_run_max;
    logic          r_run_sat;

    logic [fbs_pkg::MEAN_W-1:0] r_fmean;
    logic                       r_ovalid;
    fbs_pkg::t_res              r_odata;

    logic pop, fold, div_start, div_run, cap_f, load_out;

    logic [DW:0]                run_next;
    logic                       run_ovf;
    logic [DW+7:0]              div_sum;
    logic [DW-1:0]              div_cnt;
    logic                       div_done;
    logic [fbs_pkg::MEAN_W-1:0] div_quot;

    assign o_pop   = pop;
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    assign run_next = (DW+1)'(r_run_cnt) + (DW+1)'(r_rec_cnt);
    assign run_ovf  = (run_next > (DW+1)'({RW{1'b1}}));

    assign div_sum = div_run ? (DW+8)'(r_run_sum) : (DW+8)'(r_rec_sum);
    assign div_cnt = div_run ? DW'(r_run_cnt) : DW'(r_rec_cnt);

    fbs_divider #(
        .CNT_W (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (div_sum),
        .i_cnt   (div_cnt),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbs_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        pop       = 1'b0;
        fold      = 1'b0;
        div_start = 1'b0;
        div_run   = 1'b0;
        cap_f     = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            fbs_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    pop     = 1'b1;
                    n_state = fbs_pkg::BK_FOLD;
                end
            end
            fbs_pkg::BK_FOLD: begin
                fold      = 1'b1;
                div_start = 1'b1;
                n_state   = fbs_pkg::BK_FDIV;
            end
            fbs_pkg::BK_FDIV: begin
                if (div_done) begin
                    // Running totals were folded in already, so the second
                    // division sees this frame included.
                    cap_f     = 1'b1;
                    div_start = 1'b1;
                    div_run   = 1'b1;
                    n_state   = fbs_pkg::BK_RDIV;
                end
            end
            fbs_pkg::BK_RDIV: begin
                if (div_done) begin
                    n_state = fbs_pkg::BK_OUT;
                end
            end
            fbs_pkg::BK_OUT: begin
                if (!r_ovalid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = fbs_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = fbs_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_rec_sat <= i_rec[0];
            r_rec_max <= i_rec[8:1];
            r_rec_min <= i_rec[16:9];
            r_rec_cnt <= i_rec[FW+16:17];
            r_rec_sum <= i_rec[REC_W-1:FW+17];
        end
        if (cap_f) begin
            r_fmean <= div_quot;
        end
        if (load_out) begin
            r_odata.frame_mean_x100   <= r_fmean;
            r_odata.frame_min         <= r_rec_min;
            r_odata.frame_max         <= r_rec_max;
            r_odata.frame_total       <= fbs_pkg::OUT_TOTAL_W'(r_rec_sum);
            r_odata.frame_bytes       <= fbs_pkg::OUT_BYTES_W'(r_rec_cnt);
            r_odata.run_mean_x100     <= div_quot;
            r_odata.run_min           <= r_run_min;
            r_odata.run_max           <= r_run_max;
            r_odata.frame_overflow    <= r_rec_sat;
            r_odata.overall_overflow  <= r_run_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_sum <= '0;
            r_run_cnt <= '0;
            r_run_min <= fbs_pkg::PIX_MAX;
            r_run_max <= '0;
            r_run_sat <= 1'b0;
        end else if (fold) begin
            if (run_ovf) begin
                r_run_sat <= 1'b1;
            end else begin
                r_run_cnt <= RW'(run_next);
                r_run_sum <= r_run_sum + (RW+8)'(r_rec_sum);
            end
            if (r_rec_min < r_run_min) begin
                r_run_min <= r_rec_min;
            end
            if (r_rec_max > r_run_max) begin
                r_run_max <= r_rec_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end
endmodule
